@@ design/modexp_pkg.sv @@
package modexp_pkg;

  localparam int WIDTH = 64;
  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [WIDTH-1:0] MOD_RESET = WIDTH'(64'd2013265921);

  typedef enum logic {
    OP_POWER   = 1'b0,
    OP_INVERSE = 1'b1
  } modexp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_RED_W,
    ST_SCAN,
    ST_MUL,
    ST_MUL_W,
    ST_SQ,
    ST_SQ_W,
    ST_FINISH
  } modexp_state_t;

  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] x;
    logic [WIDTH-1:0] y;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] prod;
  } mm_rsp_t;

  // Sum of two residues, wrapped back below the modulus with one subtraction.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    logic [WIDTH-1:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s[WIDTH-1:0] - m;
    if (s[WIDTH] || (s[WIDTH-1:0] >= m)) begin
      return d;
    end
    return s[WIDTH-1:0];
  endfunction

endpackage

@@ design/modexp_if.sv @@
interface modexp_in_if import modexp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] exponent;
  modport source (output valid, output operation, output base, output exponent, input ready);
  modport sink (input valid, input operation, input base, input exponent, output ready);
endinterface

interface modexp_out_if import modexp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result;
  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

interface modexp_cfg_if import modexp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/modular_exponentiation.sv @@
// Computes base^exponent mod M, or base^(M-2) mod M for the inverse operation, by
// right-to-left square-and-multiply; M is the modulus register (the user must write it
// through the configuration channel only while the block is idle; the block itself does
// not enforce this). One item is processed at a time. All products go through a single
// bit-serial multiply-reduce unit. An item costs one base reduction, one multiply per set
// exponent bit and one squaring per exponent bit below the top set bit.
// A zero modulus gives 0; the result waits in an output register, and the next item is
// accepted while it waits.
module modular_exponentiation import modexp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  modexp_in_if.sink    in_ch,
  modexp_out_if.source out_ch,
  modexp_cfg_if.sink   cfg_ch
);

  modexp_state_t    state_r, state_nxt;
  logic [WIDTH-1:0] modulus_r;
  logic [WIDTH-1:0] base_r;
  logic [WIDTH-1:0] exp_r;
  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] sq_r;
  logic             out_valid_r;
  logic [WIDTH-1:0] out_result_r;
  logic             out_free;
  logic             in_fire;
  mm_req_t          mm_req;
  mm_rsp_t          mm_rsp;

  modexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (modulus_r),
    .req     (mm_req),
    .rsp     (mm_rsp)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (modulus_r == '0) ? ST_FINISH : ST_RED;
        end
      end
      ST_RED:   state_nxt = ST_RED_W;
      ST_RED_W: if (mm_rsp.done) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (exp_r == '0) begin
          state_nxt = ST_FINISH;
        end else if (exp_r[0]) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_SQ;
        end
      end
      ST_MUL: state_nxt = ST_MUL_W;
      ST_MUL_W: begin
        if (mm_rsp.done) begin
          state_nxt = (exp_r[WIDTH-1:1] == '0) ? ST_FINISH : ST_SQ;
        end
      end
      ST_SQ:    state_nxt = ST_SQ_W;
      ST_SQ_W:  if (mm_rsp.done) state_nxt = ST_SCAN;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mm_req = '0;
    unique case (state_r)
      ST_RED: begin
        mm_req.start = 1'b1;
        mm_req.x     = WIDTH'(1);
        mm_req.y     = base_r;
      end
      ST_MUL: begin
        mm_req.start = 1'b1;
        mm_req.x     = acc_r;
        mm_req.y     = sq_r;
      end
      ST_SQ: begin
        mm_req.start = 1'b1;
        mm_req.x     = sq_r;
        mm_req.y     = sq_r;
      end
      default: mm_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      base_r <= in_ch.base;
      exp_r  <= (in_ch.operation == OP_INVERSE) ? (modulus_r - WIDTH'(2)) : in_ch.exponent;
      acc_r  <= (modulus_r == '0) ? '0 : WIDTH'(1);
    end
    if (mm_rsp.done) begin
      unique case (state_r)
        ST_RED_W: sq_r <= mm_rsp.prod;
        ST_MUL_W: acc_r <= mm_rsp.prod;
        ST_SQ_W: begin
          sq_r  <= mm_rsp.prod;
          exp_r <= exp_r >> 1;
        end
        default: ;
      endcase
    end
    if (state_r == ST_FINISH && out_free) begin
      out_result_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        modulus_r <= cfg_ch.data;
      end
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = out_result_r;

endmodule

@@ design/modexp_mulmod.sv @@
module modexp_mulmod import modexp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIDTH-1:0] modulus,
  input  mm_req_t          req,
  output mm_rsp_t          rsp
);

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] x_r, x_nxt;
  logic [WIDTH-1:0] y_r, y_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             phase_r, phase_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH-1:0] sum;
  logic             advance;

  assign sum = add_mod(acc_r, phase_r ? x_r : acc_r, modulus);

  always_comb begin
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    advance   = 1'b0;
    if (req.start) begin
      acc_nxt   = '0;
      x_nxt     = req.x;
      y_nxt     = req.y;
      cnt_nxt   = CNT_W'(WIDTH - 1);
      phase_nxt = 1'b0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum;
      if (!phase_r && y_r[WIDTH-1]) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        advance   = 1'b1;
      end
      if (advance) begin
        y_nxt = {y_r[WIDTH-2:0], 1'b0};
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      phase_r <= 1'b0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

@@ test/tb_modular_exponentiation.sv @@
module tb_modular_exponentiation;
  import modexp_pkg::*;

  typedef struct {
    modexp_op_t       op;
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] exponent;
  } modexp_item_t;

  localparam logic [WIDTH-1:0] PRIME_TOP = WIDTH'(64'hFFFF_FFFF_FFFF_FFC5);
  localparam int HOLD_CYCLES = 4000;

  logic clk;
  logic rst_n;

  modexp_in_if  in_ch ();
  modexp_out_if out_ch ();
  modexp_cfg_if cfg_ch ();

  modular_exponentiation DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  modexp_item_t     pending_items[$];
  logic [WIDTH-1:0] expected_results[$];
  logic [WIDTH-1:0] modulus_copy;

  int unsigned items_queued;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned inverse_items;
  int unsigned modulus_writes;
  int unsigned send_gap;
  int unsigned recv_wait;
  bit          in_fire;
  bit          out_fire;
  bit          send_idle;
  bit          recv_idle;
  bit          hold_armed;
  bit          recv_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #480_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [WIDTH-1:0] mul_reduce(input logic [WIDTH-1:0] a,
                                                  input logic [WIDTH-1:0] b,
                                                  input logic [WIDTH-1:0] m);
    logic [2*WIDTH-1:0] p;
    p = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
    return WIDTH'(p % {{WIDTH{1'b0}}, m});
  endfunction

  // The running result starts at 1 and is only reduced once a set exponent bit is met.
  function automatic logic [WIDTH-1:0] expected_power(input modexp_op_t op,
                                                      input logic [WIDTH-1:0] b,
                                                      input logic [WIDTH-1:0] e_in,
                                                      input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] acc;
    logic [WIDTH-1:0] sq;
    logic [WIDTH-1:0] e;
    e = (op == OP_INVERSE) ? m - WIDTH'(2) : e_in;
    if (m == '0) begin
      return '0;
    end
    acc = WIDTH'(1);
    sq = b % m;
    while (e != '0) begin
      if (e[0]) begin
        acc = mul_reduce(acc, sq, m);
      end
      sq = mul_reduce(sq, sq, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [WIDTH-1:0] random_word();
    return WIDTH'({$urandom, $urandom});
  endfunction

  function automatic logic [WIDTH-1:0] low_bits(input int unsigned n);
    return (n >= WIDTH) ? '1 : ((WIDTH'(1) << n) - WIDTH'(1));
  endfunction

  function automatic int unsigned idle_gap(input bit enabled);
    return enabled ? $urandom_range(0, 11) : 0;
  endfunction

  // Most exponents are short so that the run stays fast; a few use the full width.
  function automatic modexp_item_t random_item();
    modexp_item_t it;
    int unsigned  pick;
    int unsigned  bits;
    pick = $urandom_range(0, 99);
    bits = (pick < 3) ? WIDTH : (pick < 20) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    it.op = ($urandom_range(0, 9) == 0) ? OP_INVERSE : OP_POWER;
    it.exponent = random_word() & low_bits(bits);
    case ($urandom_range(0, 9))
      0: it.base = '0;
      1: it.base = '1;
      2: it.base = WIDTH'($urandom_range(0, 300));
      default: it.base = random_word();
    endcase
    return it;
  endfunction

  task automatic queue_item(input modexp_op_t op, input logic [WIDTH-1:0] b,
                            input logic [WIDTH-1:0] e);
    modexp_item_t it;
    it.op = op;
    it.base = b;
    it.exponent = e;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic drain_phase();
    wait (results_checked == items_queued);
  endtask

  task automatic write_modulus(input logic [WIDTH-1:0] m);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    modulus_writes++;
  endtask

  task automatic note_mismatch(input string what, input logic [WIDTH-1:0] want,
                               input logic [WIDTH-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%t: %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(negedge clk) begin : drive_items
    modexp_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_ch.valid || in_fire) begin
      if (send_gap != 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= it.op;
        in_ch.base <= it.base;
        in_ch.exponent <= it.exponent;
        send_gap <= idle_gap(send_idle);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    int unsigned stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_wait <= 0;
    end else if (recv_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall = out_fire ? idle_gap(recv_idle) : recv_wait;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        recv_wait <= stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        recv_wait <= 0;
      end
    end
  end

  initial begin
    recv_hold = 1'b0;
    wait (hold_armed);
    @(posedge clk);
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_hold = 1'b0;
  end

  always @(posedge clk) begin : watch_ports
    logic [WIDTH-1:0] want;
    if (!rst_n) begin
      in_fire = 1'b0;
      out_fire = 1'b0;
    end else begin
      in_fire = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        modulus_copy = cfg_ch.data;
      end
      if (in_fire) begin
        expected_results.push_back(expected_power(modexp_op_t'(in_ch.operation), in_ch.base,
                                                  in_ch.exponent, modulus_copy));
        if (in_ch.operation == OP_INVERSE) begin
          inverse_items++;
        end
      end
      if (out_fire) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result with no item pending", '0, out_ch.result);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (out_ch.result !== want) begin
            note_mismatch("result", want, out_ch.result);
          end
        end
      end
    end
  end

  initial begin
    modexp_item_t     it;
    logic [WIDTH-1:0] phase_mod [8];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.base = '0;
    in_ch.exponent = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_armed = 1'b0;
    modulus_copy = MOD_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items on the modulus left by reset.
    queue_item(OP_POWER, '0, '0);
    queue_item(OP_POWER, '1, '1);
    queue_item(OP_POWER, WIDTH'(5), WIDTH'(1));
    queue_item(OP_POWER, MOD_RESET, WIDTH'(7));
    queue_item(OP_POWER, '1, '0);
    queue_item(OP_INVERSE, '0, random_word());
    queue_item(OP_INVERSE, WIDTH'(3), '1);
    queue_item(OP_INVERSE, random_word(), '0);
    drain_phase();

    // A zero modulus gives zero for every item.
    write_modulus('0);
    queue_item(OP_POWER, WIDTH'(5), WIDTH'(3));
    queue_item(OP_INVERSE, WIDTH'(7), '1);
    queue_item(OP_POWER, '0, '0);
    drain_phase();

    // With a modulus of one the inverse exponent wraps to all ones.
    write_modulus(WIDTH'(1));
    queue_item(OP_POWER, WIDTH'(5), '0);
    queue_item(OP_POWER, WIDTH'(5), WIDTH'(9));
    queue_item(OP_INVERSE, WIDTH'(4), '0);
    drain_phase();

    write_modulus(WIDTH'(2));
    queue_item(OP_INVERSE, WIDTH'(3), '0);
    queue_item(OP_POWER, WIDTH'(3), WIDTH'(5));
    queue_item(OP_POWER, '1, '1);
    drain_phase();

    // An all-ones modulus is not prime; the inverse power is returned as computed.
    write_modulus('1);
    queue_item(OP_INVERSE, WIDTH'(2), '0);
    queue_item(OP_POWER, '1, '1);
    queue_item(OP_POWER, '1 - WIDTH'(1), WIDTH'(3));
    drain_phase();

    write_modulus(PRIME_TOP);
    queue_item(OP_INVERSE, random_word(), '0);
    queue_item(OP_INVERSE, '0, '0);
    queue_item(OP_POWER, '1, WIDTH'(2));
    drain_phase();

    phase_mod[0] = MOD_RESET;
    phase_mod[1] = WIDTH'(251);
    phase_mod[2] = WIDTH'(65537);
    phase_mod[3] = PRIME_TOP;
    phase_mod[4] = random_word() | WIDTH'(1);
    phase_mod[5] = WIDTH'($urandom_range(2, 1000));
    phase_mod[6] = '1;
    phase_mod[7] = WIDTH'($urandom);

    for (int k = 0; k < 8; k++) begin
      write_modulus(phase_mod[k]);
      send_idle = k[0];
      recv_idle = k[1];
      // The receiver stalls for a long stretch here so that the input backs up.
      if (k == 1) begin
        hold_armed = 1'b1;
      end
      for (int n = 0; n < 60; n++) begin
        it = random_item();
        queue_item(it.op, it.base, it.exponent);
      end
      drain_phase();
    end

    repeat (200) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatch_count += expected_results.size();
      $display("%0d results never arrived", expected_results.size());
    end
    $display("Checked %0d results (%0d inverse items) across %0d modulus writes.",
             results_checked, inverse_items, modulus_writes);
    $display("Mismatches: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
